/* sv/triangle_unit_normal_defines.svh */
// Assertion macros for the triangle unit normal block.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("implication check failed");
`define ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("invariant check failed");
`else
`define ASSERT_IMPLIES(lbl, pre, post)
`define ASSERT_ALWAYS(lbl, cond)
`endif
`endif

/* sv/tun_pkg.sv */
// Shared widths and types for the triangle unit normal pipeline.
package tun_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OUT_BITS   = 16;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = PROD_BITS;
   localparam int LO_BITS    = (MAG_BITS + 1) / 2;
   localparam int HI_BITS    = MAG_BITS - LO_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int LEN_BITS   = SQ_BITS + 2;
   localparam int REM_BITS   = LEN_BITS + 1;
   localparam int QUO_BITS   = 2 * FRAC_BITS + 1;
   localparam int ROOT_BITS  = FRAC_BITS + 1;
   localparam int SQRT_BITS  = QUO_BITS + 1;

   typedef struct packed {
      logic       valid;
      logic       degen;
      logic [2:0] neg;
   } tun_ctl_type;
endpackage

/* sv/tun_cross.sv */
// Edge vectors and cross product, three register stages.
module tun_cross
   import tun_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [2:0][COORD_BITS-1:0] a,
   input  logic [2:0][COORD_BITS-1:0] b,
   input  logic [2:0][COORD_BITS-1:0] c,
   output tun_ctl_type                ctl,
   output logic [MAG_BITS-1:0]        mag [3]
);
   logic signed [EDGE_BITS-1:0]  e1_ff [3], e1_in [3];
   logic signed [EDGE_BITS-1:0]  e2_ff [3], e2_in [3];
   logic signed [PROD_BITS-1:0]  p_ff [3], p_in [3];
   logic signed [PROD_BITS-1:0]  q_ff [3], q_in [3];
   logic [CROSS_BITS-1:0]        diff [3], ndiff [3];
   logic [MAG_BITS-1:0]          mag_ff [3], mag_in [3];
   logic [2:0]                   neg_ff, neg_in;
   logic                         degen_ff, degen_in;
   logic [2:0]                   valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = $signed({b[i][COORD_BITS-1], b[i]}) - $signed({a[i][COORD_BITS-1], a[i]});
         e2_in[i] = $signed({c[i][COORD_BITS-1], c[i]}) - $signed({a[i][COORD_BITS-1], a[i]});
      end
      for (int i = 0; i < 3; i++) begin
         p_in[i] = e1_ff[(i + 1) % 3] * e2_ff[(i + 2) % 3];
         q_in[i] = e1_ff[(i + 2) % 3] * e2_ff[(i + 1) % 3];
      end
      for (int i = 0; i < 3; i++) begin
         diff[i]   = {p_ff[i][PROD_BITS-1], p_ff[i]} - {q_ff[i][PROD_BITS-1], q_ff[i]};
         ndiff[i]  = -diff[i];
         neg_in[i] = diff[i][CROSS_BITS-1];
         mag_in[i] = neg_in[i] ? ndiff[i][MAG_BITS-1:0] : diff[i][MAG_BITS-1:0];
      end
      degen_in = (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         p_ff     <= p_in;
         q_ff     <= q_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         degen_ff <= degen_in;
      end
   end

   assign ctl.valid = valid_ff[2];
   assign ctl.degen = degen_ff;
   assign ctl.neg   = neg_ff;
   assign mag       = mag_ff;
endmodule

/* sv/tun_square.sv */
// Component squares and squared length, three register stages.
module tun_square
   import tun_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  tun_ctl_type         ctl_i,
   input  logic [MAG_BITS-1:0] mag [3],
   output tun_ctl_type         ctl_o,
   output logic [SQ_BITS-1:0]  sq [3],
   output logic [LEN_BITS-1:0] len
);
   logic [2*HI_BITS-1:0]         hh_ff [3], hh_in [3];
   logic [HI_BITS+LO_BITS-1:0]   hl_ff [3], hl_in [3];
   logic [2*LO_BITS-1:0]         ll_ff [3], ll_in [3];
   logic [SQ_BITS-1:0]           sq1_ff [3], sq1_in [3];
   logic [SQ_BITS-1:0]           sq2_ff [3];
   logic [LEN_BITS-1:0]          len_ff, len_in;
   tun_ctl_type                  ctl_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hh_in[i] = mag[i][MAG_BITS-1:LO_BITS] * mag[i][MAG_BITS-1:LO_BITS];
         hl_in[i] = mag[i][MAG_BITS-1:LO_BITS] * mag[i][LO_BITS-1:0];
         ll_in[i] = mag[i][LO_BITS-1:0] * mag[i][LO_BITS-1:0];
         sq1_in[i] = (SQ_BITS'(hh_ff[i]) << (2 * LO_BITS))
                   + (SQ_BITS'(hl_ff[i]) << (LO_BITS + 1))
                   + SQ_BITS'(ll_ff[i]);
      end
      len_in = LEN_BITS'(sq1_ff[0]) + LEN_BITS'(sq1_ff[1]) + LEN_BITS'(sq1_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
         ctl_ff[1].valid <= 1'b0;
         ctl_ff[2].valid <= 1'b0;
      end else if (en) begin
         ctl_ff[0].valid <= ctl_i.valid;
         ctl_ff[1].valid <= ctl_ff[0].valid;
         ctl_ff[2].valid <= ctl_ff[1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0].degen <= ctl_i.degen;
         ctl_ff[0].neg   <= ctl_i.neg;
         ctl_ff[1].degen <= ctl_ff[0].degen;
         ctl_ff[1].neg   <= ctl_ff[0].neg;
         ctl_ff[2].degen <= ctl_ff[1].degen;
         ctl_ff[2].neg   <= ctl_ff[1].neg;
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         ll_ff  <= ll_in;
         sq1_ff <= sq1_in;
         sq2_ff <= sq1_ff;
         len_ff <= len_in;
      end
   end

   assign ctl_o = ctl_ff[2];
   assign sq    = sq2_ff;
   assign len   = len_ff;
endmodule

/* sv/tun_divide.sv */
// Restoring divider, one quotient bit per stage: q = sq * 4^F / len.
module tun_divide
   import tun_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  tun_ctl_type         ctl_i,
   input  logic [SQ_BITS-1:0]  sq [3],
   input  logic [LEN_BITS-1:0] len,
   output tun_ctl_type         ctl_o,
   output logic [QUO_BITS-1:0] quo [3]
);
   logic [REM_BITS-1:0] rem_ff [QUO_BITS+1][3];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS+1][3];
   logic [LEN_BITS-1:0] len_ff [QUO_BITS+1];
   tun_ctl_type         ctl_ff [QUO_BITS+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_ff[0][i] = REM_BITS'(sq[i]);
         quo_ff[0][i] = '0;
      end
      len_ff[0] = len;
      ctl_ff[0] = ctl_i;
   end

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
      logic [REM_BITS-1:0] rem_in [3];
      logic [QUO_BITS-1:0] quo_in [3];
      logic [REM_BITS-1:0] red;
      logic                ge;

      always_comb begin
         red = '0;
         ge  = 1'b0;
         for (int i = 0; i < 3; i++) begin
            ge        = rem_ff[s][i] >= REM_BITS'(len_ff[s]);
            red       = ge ? rem_ff[s][i] - REM_BITS'(len_ff[s]) : rem_ff[s][i];
            rem_in[i] = {red[REM_BITS-2:0], 1'b0};
            quo_in[i] = {quo_ff[s][i][QUO_BITS-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[s+1].valid <= ctl_ff[s].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[s+1].degen <= ctl_ff[s].degen;
            ctl_ff[s+1].neg   <= ctl_ff[s].neg;
            len_ff[s+1]       <= len_ff[s];
            rem_ff[s+1]       <= rem_in;
            quo_ff[s+1]       <= quo_in;
         end
      end
   end

   assign ctl_o = ctl_ff[QUO_BITS];
   assign quo   = quo_ff[QUO_BITS];
endmodule

/* sv/tun_sqrt.sv */
// Digit-by-digit integer square root, one result bit per stage.
module tun_sqrt
   import tun_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  tun_ctl_type          ctl_i,
   input  logic [QUO_BITS-1:0]  quo [3],
   output tun_ctl_type          ctl_o,
   output logic [ROOT_BITS-1:0] root [3]
);
   logic [SQRT_BITS-1:0] op_ff  [ROOT_BITS+1][3];
   logic [SQRT_BITS-1:0] res_ff [ROOT_BITS+1][3];
   tun_ctl_type          ctl_ff [ROOT_BITS+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         op_ff[0][i]  = SQRT_BITS'(quo[i]);
         res_ff[0][i] = '0;
      end
      ctl_ff[0] = ctl_i;
   end

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      localparam logic [SQRT_BITS-1:0] One = SQRT_BITS'(1) << (2 * (FRAC_BITS - k));
      logic [SQRT_BITS-1:0] op_in [3];
      logic [SQRT_BITS-1:0] res_in [3];
      logic [SQRT_BITS-1:0] trial;

      always_comb begin
         trial = '0;
         for (int i = 0; i < 3; i++) begin
            trial = res_ff[k][i] + One;
            if (op_ff[k][i] >= trial) begin
               op_in[i]  = op_ff[k][i] - trial;
               res_in[i] = (res_ff[k][i] >> 1) + One;
            end else begin
               op_in[i]  = op_ff[k][i];
               res_in[i] = res_ff[k][i] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[k+1].valid <= ctl_ff[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[k+1].degen <= ctl_ff[k].degen;
            ctl_ff[k+1].neg   <= ctl_ff[k].neg;
            op_ff[k+1]        <= op_in;
            res_ff[k+1]       <= res_in;
         end
      end
   end

   assign ctl_o = ctl_ff[ROOT_BITS];
   always_comb begin
      for (int i = 0; i < 3; i++) root[i] = res_ff[ROOT_BITS][i][ROOT_BITS-1:0];
   end
endmodule

/* sv/triangle_unit_normal.sv */
// Pipeline stages from accepted req word to rsp word: 3 cross, 3 square, 29 divide,
// 15 square-root, 1 output stage. Throughput: one triangle per cycle while no rsp word is held.
// The whole pipeline advances on one enable; a held rsp word (rsp_tvalid high,
// rsp_tready low) freezes every stage and deasserts req_tready.
// Reset clears all valid bits; data registers are not reset.
`include "triangle_unit_normal_defines.svh"
module triangle_unit_normal
   import tun_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z, 16 bits each
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // n_x, n_y, n_z, 16 bits each
   output logic [0:0]   rsp_tuser   // degenerate
);
   logic                          en;
   logic [2:0][COORD_BITS-1:0]    va, vb, vc;
   tun_ctl_type                   ctl_c, ctl_s, ctl_d, ctl_r;
   logic [MAG_BITS-1:0]           mag [3];
   logic [SQ_BITS-1:0]            sq [3];
   logic [LEN_BITS-1:0]           len;
   logic [QUO_BITS-1:0]           quo [3];
   logic [ROOT_BITS-1:0]          root [3];
   logic [OUT_BITS-1:0]           pos [3], val_in [3];
   logic [OUT_BITS-1:0]           val_ff [3];
   logic                          degen_ff;
   logic                          valid_ff;
   logic signed [OUT_BITS-1:0]    nx_out;

   assign en         = !valid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va[i] = req_tdata[(0 + i) * COORD_BITS +: COORD_BITS];
         vb[i] = req_tdata[(3 + i) * COORD_BITS +: COORD_BITS];
         vc[i] = req_tdata[(6 + i) * COORD_BITS +: COORD_BITS];
      end
   end

   tun_cross u_cross (
      .clock, .reset, .en, .in_valid(req_tvalid),
      .a(va), .b(vb), .c(vc), .ctl(ctl_c), .mag
   );

   tun_square u_square (
      .clock, .reset, .en, .ctl_i(ctl_c), .mag, .ctl_o(ctl_s), .sq, .len
   );

   tun_divide u_divide (
      .clock, .reset, .en, .ctl_i(ctl_s), .sq, .len, .ctl_o(ctl_d), .quo
   );

   tun_sqrt u_sqrt (
      .clock, .reset, .en, .ctl_i(ctl_d), .quo, .ctl_o(ctl_r), .root
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i]    = OUT_BITS'(root[i]);
         val_in[i] = ctl_r.degen ? '0 : (ctl_r.neg[i] ? -pos[i] : pos[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl_r.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff   <= val_in;
         degen_ff <= ctl_r.degen;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {val_ff[2], val_ff[1], val_ff[0]};
   assign rsp_tuser  = degen_ff;
   assign nx_out     = rsp_tdata[15:0];

   `ASSERT_IMPLIES(a_degen_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == 48'd0)
   `ASSERT_IMPLIES(a_nx_range, rsp_tvalid, nx_out <= 16'sd16384 && nx_out >= -16'sd16384)
   `ASSERT_ALWAYS(a_ready_rule, req_tready == (!rsp_tvalid || rsp_tready))
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the triangle unit normal pipeline.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tun_pkg::*;

   typedef struct packed {
      logic signed [15:0] nx, ny, nz;
      logic               degen;
   } normal_type;

   typedef struct {
      logic [143:0] tri_word;
      logic         known;
      normal_type   want;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   normal_type   normal_queue[$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   bit           sending_done = 0;
   bit           no_idle = 0;
   bit           hold_rsp = 0;
   bit           timed_out = 0;

   triangle_unit_normal DUT (.*);

   always #5 clock = ~clock;

   // floor(sqrt(v)) for a nonnegative value
   function automatic logic [127:0] isqrt(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] bitv;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         bitv = r | (128'd1 << i);
         if (bitv * bitv <= v) r = bitv;
      end
      return r;
   endfunction

   function automatic normal_type face_normal(input logic [143:0] w);
      logic signed [17:0] c[9];
      logic signed [17:0] e1[3], e2[3];
      logic signed [63:0] n[3];
      logic [127:0]       len2, mag, q, tgt;
      logic [15:0]        res[3];
      normal_type         r;
      for (int i = 0; i < 9; i++) c[i] = $signed(w[16*i +: 16]);
      for (int i = 0; i < 3; i++) begin
         e1[i] = c[3+i] - c[i];
         e2[i] = c[6+i] - c[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
         mag = n[i] < 0 ? 128'(-n[i]) : 128'(n[i]);
         len2 += mag * mag;
      end
      if (len2 == 0) begin
         r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         mag = n[i] < 0 ? 128'(-n[i]) : 128'(n[i]);
         tgt = (mag * mag) << 28;
         // largest q with q*q*len2 <= tgt
         q = isqrt(tgt / len2);
         while (q > 0 && q * q * len2 > tgt) q--;
         while ((q + 1) * (q + 1) * len2 <= tgt) q++;
         res[i] = n[i] < 0 ? 16'(-q) : 16'(q);
      end
      r.nx = res[0]; r.ny = res[1]; r.nz = res[2]; r.degen = 0;
      return r;
   endfunction

   function automatic logic [143:0] pack_tri(input int v[9]);
      logic [143:0] w;
      for (int i = 0; i < 9; i++) w[16*i +: 16] = 16'(v[i]);
      return w;
   endfunction

   function automatic logic [143:0] random_tri();
      logic [143:0] w;
      int           k;
      int           amp;
      for (int i = 0; i < 9; i++) w[16*i +: 16] = 16'($urandom);
      k = $urandom_range(0, 9);
      if (k < 3) begin
         amp = 1 << $urandom_range(1, 12);
         for (int i = 0; i < 9; i++) w[16*i +: 16] = 16'(int'($urandom_range(0, 2*amp)) - amp);
      end else if (k == 3) begin
         w[16*3 +: 48] = w[0 +: 48];
      end else if (k == 4) begin
         // collinear: C = A + 2(B - A)
         for (int i = 0; i < 3; i++) begin
            w[16*i +: 16]     = 16'($urandom_range(0, 255) - 128);
            w[16*(3+i) +: 16] = 16'($urandom_range(0, 255) - 128);
            w[16*(6+i) +: 16] = 16'(2 * $signed(w[16*(3+i) +: 16]) - $signed(w[16*i +: 16]));
         end
      end else if (k == 5) begin
         for (int i = 0; i < 9; i++) w[16*i +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      end
      return w;
   endfunction

   task automatic send_tri(input logic [143:0] w);
      int gap;
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      normal_queue.push_back(face_normal(w));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (normal_queue.size() != 0) @(negedge clock);
   endtask

   initial begin
      row_type rows[$];
      row_type row;
      normal_type got;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      row.known = 1;
      row.want = '{0, 0, 0, 1};
      row.tri_word = '0; rows.push_back(row);
      row.tri_word = {9{16'h8000}}; rows.push_back(row);
      row.tri_word = {9{16'h7fff}}; rows.push_back(row);
      row.tri_word = pack_tri('{1, 2, 3, 2, 4, 6, 3, 6, 9}); rows.push_back(row);
      row.want = '{0, 0, 16384, 0};
      row.tri_word = pack_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0}); rows.push_back(row);
      row.want = '{0, 0, -16384, 0};
      row.tri_word = pack_tri('{0, 0, 0, 0, 256, 0, 256, 0, 0}); rows.push_back(row);
      row.want = '{16384, 0, 0, 0};
      row.tri_word = pack_tri('{0, 0, 0, 0, 1, 0, 0, 0, 1}); rows.push_back(row);
      row.want = '{0, 16384, 0, 0};
      row.tri_word = pack_tri('{5, 5, 5, 5, 5, 6, 6, 5, 5}); rows.push_back(row);
      row.known = 0;
      row.tri_word = pack_tri('{-32768, -32768, -32768, 32767, -32768, -32768,
                                -32768, 32767, -32768}); rows.push_back(row);
      row.tri_word = pack_tri('{32767, 32767, 32767, -32768, 32767, -32768,
                                32767, -32768, -32768}); rows.push_back(row);
      row.tri_word = pack_tri('{-32768, 32767, 0, 32767, -32768, 32767,
                                0, 0, -32768}); rows.push_back(row);
      row.tri_word = pack_tri('{0, 0, 0, 1, 1, 0, -1, 1, 1}); rows.push_back(row);
      row.tri_word = pack_tri('{100, -200, 300, -400, 500, -600, 700, -800, 900});
      rows.push_back(row);
      foreach (rows[i]) begin
         if (rows[i].known) begin
            got = face_normal(rows[i].tri_word);
            if (got != rows[i].want) begin
               mismatches++;
               $display("predictor row %0d: want %p got %p", i, rows[i].want, got);
            end
         end
         send_tri(rows[i].tri_word);
      end
      for (int i = 0; i < 1600; i++) begin
         if (i == 400) begin
            hold_rsp = 1;
            for (int j = 0; j < 120; j++) send_tri(random_tri());
            hold_rsp = 0;
         end
         if (i == 800) drain();
         if (i == 1300) no_idle = 1;
         send_tri(random_tri());
      end
      req_tvalid <= 1'b0;
      sending_done = 1;
   end

   // receiver: random stalls, one long hold-off
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < 200; n++) @(negedge clock);
            rsp_tready <= 1'b1;
            wait (!hold_rsp);
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (normal_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = normal_queue.pop_front();
            if (rsp_tdata[15:0] !== want.nx || rsp_tdata[31:16] !== want.ny ||
                rsp_tdata[47:32] !== want.nz || rsp_tuser[0] !== want.degen) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want n=(%0d,%0d,%0d) degen=%0b got n=(%0d,%0d,%0d) degen=%0b",
                           want.nx, want.ny, want.nz, want.degen,
                           $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]),
                           $signed(rsp_tdata[47:32]), rsp_tuser[0]);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) timed_out <= 1;
   end

   initial begin
      wait (timed_out || (sending_done && normal_queue.size() == 0));
      if (!timed_out) repeat (60) @(posedge clock);
      if (timed_out) begin
         $display("Regression FAIL");
      end else if (mismatches == 0 && normal_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
